### hdl/eia_pkg.sv
// Shared request and status codes and the ID field width for the entity ID allocator.
package eia_pkg;

  localparam int unsigned ID_W = 10;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NOT_LIVE  = 2'd2
  } status_e;

endpackage

### hdl/eia_req_if.sv
// Request channel: valid/ready handshake carrying one request beat.
interface eia_req_if;
  logic                          valid;
  logic                          ready;
  eia_pkg::req_e                 req_type;
  logic [eia_pkg::ID_W-1:0]      target_id;

  modport source (output valid, output req_type, output target_id, input ready);
  modport sink   (input valid, input req_type, input target_id, output ready);
endinterface

### hdl/eia_rsp_if.sv
// Response channel: valid/ready handshake carrying one result beat.
interface eia_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [eia_pkg::ID_W-1:0]      granted_id;
  eia_pkg::status_e              status;

  modport source (output valid, output granted_id, output status, input ready);
  modport sink   (input valid, input granted_id, input status, output ready);
endinterface

### hdl/eia_ram.sv
// Generic single-write, single-read RAM with registered read data.
module eia_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Same-address read and write return the old word.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/entity_id_allocator.sv
// Entity ID allocator: fresh counter, LIFO free list and live map, one request per cycle while rsp_o.ready holds.
//
// Usage: send one request beat per cycle on req_i (allocate, release, query or clear);
// each yields exactly one response beat on rsp_o, in order. The block sustains one
// request per clock while rsp_o.ready holds; a response passes through the registered
// reads of the free-list RAM and the live-map RAM, then into the response register.
// Allocate pops the most recently released ID, otherwise hands out the fresh counter;
// with nothing left it answers status exhausted and ID zero. Release of a live ID
// clears its live bit and pushes it; release or query of an ID that is not live, or at
// or above MAX_IDS, answers not-live. Clear is handled like any other request: the
// live map is not swept, because an ID only counts as live when it lies below the
// fresh counter and its map bit is set, and every ID below the counter had its bit
// written since the last clear. There is no clearing pass after reset. A response
// waiting for rsp_o.ready holds the working stage; a next request is then taken only
// while the working stage is empty.
module entity_id_allocator #(
  parameter int unsigned MAX_IDS = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  eia_req_if.sink   req_i,
  eia_rsp_if.source rsp_o
);

  localparam int unsigned IdW  = $clog2(MAX_IDS);
  localparam int unsigned CntW = $clog2(MAX_IDS + 1);
  // Common width for comparing port IDs against internal counters.
  localparam int unsigned CmpW = CntW + eia_pkg::ID_W;

  // ---------------------------------------------------------------------------
  // Handshake between input, working stage and response register
  // ---------------------------------------------------------------------------
  logic st_valid_q;
  logic out_valid_q;
  logic st_move;
  logic req_beat;

  // The stage advances whenever the response register is empty or being drained.
  assign st_move  = st_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_beat = req_i.valid && req_i.ready;
  assign req_i.ready = !st_valid_q || st_move;

  // ---------------------------------------------------------------------------
  // Architectural state
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] fresh_q, fresh_d;
  logic [CntW-1:0] depth_q, depth_d;

  // Working stage payload and RAM bypass captured at acceptance
  eia_pkg::req_e             st_req_q;
  logic [eia_pkg::ID_W-1:0]  st_tid_q;
  logic                      st_live_hit_q;
  logic                      st_live_fwd_q;
  logic                      st_stk_hit_q;
  logic [IdW-1:0]            st_stk_fwd_q;

  // Response register
  logic [eia_pkg::ID_W-1:0]  out_gnt_q;
  eia_pkg::status_e          out_status_q;

  // ---------------------------------------------------------------------------
  // RAM ports
  // ---------------------------------------------------------------------------
  logic            live_we;
  logic [IdW-1:0]  live_waddr;
  logic            live_wdata;
  logic [IdW-1:0]  live_raddr;
  logic            live_rdata;

  logic            stk_we;
  logic [IdW-1:0]  stk_waddr;
  logic [IdW-1:0]  stk_wdata;
  logic [IdW-1:0]  stk_raddr;
  logic [IdW-1:0]  stk_rdata;

  eia_ram #(
    .WIDTH (1),
    .DEPTH (MAX_IDS)
  ) u_live_ram (
    .clk_i     (clk_i),
    .wr_en_i   (live_we),
    .wr_addr_i (live_waddr),
    .wr_data_i (live_wdata),
    .rd_en_i   (req_beat),
    .rd_addr_i (live_raddr),
    .rd_data_o (live_rdata)
  );

  eia_ram #(
    .WIDTH (IdW),
    .DEPTH (MAX_IDS)
  ) u_stack_ram (
    .clk_i     (clk_i),
    .wr_en_i   (stk_we),
    .wr_addr_i (stk_waddr),
    .wr_data_i (stk_wdata),
    .rd_en_i   (req_beat),
    .rd_addr_i (stk_raddr),
    .rd_data_o (stk_rdata)
  );

  // ---------------------------------------------------------------------------
  // Working stage: decide the request against current state
  // ---------------------------------------------------------------------------
  logic [CmpW-1:0]          st_tid_ext;
  logic [IdW-1:0]           st_tid_addr;
  logic                     live_bit;
  logic                     tid_live;
  logic [IdW-1:0]           stk_top;
  logic [IdW-1:0]           res_gnt;
  logic [CmpW-1:0]          res_gnt_ext;
  eia_pkg::status_e         res_status;
  logic                     live_we_raw;
  logic                     stk_we_raw;
  logic [CntW-1:0]          depth_calc;
  logic [CntW-1:0]          fresh_calc;
  logic [CntW-1:0]          depth_dec;

  assign st_tid_ext  = CmpW'(st_tid_q);
  assign st_tid_addr = st_tid_ext[IdW-1:0];

  // Merge in a write that landed on the same word in the cycle the read was issued.
  assign live_bit = st_live_hit_q ? st_live_fwd_q : live_rdata;
  assign stk_top  = st_stk_hit_q  ? st_stk_fwd_q  : stk_rdata;

  // Only IDs below the fresh counter can be live; this also hides stale map bits.
  assign tid_live = (st_tid_ext < CmpW'(fresh_q)) && live_bit;

  assign depth_dec = depth_q - CntW'(1);

  always_comb begin
    res_gnt     = '0;
    res_status  = eia_pkg::ST_OK;
    live_we_raw = 1'b0;
    live_waddr  = st_tid_addr;
    live_wdata  = 1'b0;
    stk_we_raw  = 1'b0;
    stk_waddr   = depth_q[IdW-1:0];
    stk_wdata   = st_tid_addr;
    depth_calc  = depth_q;
    fresh_calc  = fresh_q;
    case (st_req_q)
      eia_pkg::REQ_ALLOC: begin
        if (depth_q != '0) begin
          // Pop the most recently released ID.
          depth_calc  = depth_dec;
          res_gnt     = stk_top;
          live_we_raw = 1'b1;
          live_waddr  = stk_top;
          live_wdata  = 1'b1;
        end else if (fresh_q < CntW'(MAX_IDS)) begin
          res_gnt     = fresh_q[IdW-1:0];
          fresh_calc  = fresh_q + CntW'(1);
          live_we_raw = 1'b1;
          live_waddr  = fresh_q[IdW-1:0];
          live_wdata  = 1'b1;
        end else begin
          res_status = eia_pkg::ST_EXHAUSTED;
        end
      end
      eia_pkg::REQ_RELEASE: begin
        if (tid_live) begin
          live_we_raw = 1'b1;
          if (depth_q < CntW'(MAX_IDS)) begin
            stk_we_raw = 1'b1;
            depth_calc = depth_q + CntW'(1);
          end
        end else begin
          res_status = eia_pkg::ST_NOT_LIVE;
        end
      end
      eia_pkg::REQ_QUERY: begin
        res_status = tid_live ? eia_pkg::ST_OK : eia_pkg::ST_NOT_LIVE;
      end
      default: begin
        // Clear: drop the counter and the free list; map bits go stale.
        fresh_calc = '0;
        depth_calc = '0;
      end
    endcase
  end

  // Commit only when the stage hands its result to the response register.
  assign live_we = live_we_raw && st_move;
  assign stk_we  = stk_we_raw  && st_move;
  assign depth_d = st_move ? depth_calc : depth_q;
  assign fresh_d = st_move ? fresh_calc : fresh_q;

  assign res_gnt_ext = CmpW'(res_gnt);

  // ---------------------------------------------------------------------------
  // Read addresses for the incoming request, from state after this cycle's commit
  // ---------------------------------------------------------------------------
  logic [CmpW-1:0] req_tid_ext;
  logic [CntW-1:0] depth_top;
  logic            live_hit_d;
  logic            stk_hit_d;

  assign req_tid_ext = CmpW'(req_i.target_id);
  assign live_raddr  = req_tid_ext[IdW-1:0];
  assign depth_top   = (depth_d == '0) ? '0 : depth_d - CntW'(1);
  assign stk_raddr   = depth_top[IdW-1:0];

  // A write in the same cycle as the read is missed by the RAM; catch it here.
  assign live_hit_d = live_we && (live_waddr == live_raddr);
  assign stk_hit_d  = stk_we  && (stk_waddr  == stk_raddr);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fresh_q     <= '0;
      depth_q     <= '0;
    end else begin
      fresh_q <= fresh_d;
      depth_q <= depth_d;
      if (req_i.ready) begin
        st_valid_q <= req_i.valid;
      end
      if (st_move) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: capture the request with its bypass, and the result on advance.
  always_ff @(posedge clk_i) begin
    if (req_beat) begin
      st_req_q      <= req_i.req_type;
      st_tid_q      <= req_i.target_id;
      st_live_hit_q <= live_hit_d;
      st_live_fwd_q <= live_wdata;
      st_stk_hit_q  <= stk_hit_d;
      st_stk_fwd_q  <= stk_wdata;
    end
    if (st_move) begin
      out_gnt_q    <= res_gnt_ext[eia_pkg::ID_W-1:0];
      out_status_q <= res_status;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.granted_id = out_gnt_q;
  assign rsp_o.status     = out_status_q;

endmodule

### hdl/eia_checker.sv
// Port-level checker for the entity ID allocator, bound to the top level.
module eia_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     req_valid_i,
  input logic                     req_ready_i,
  input eia_pkg::req_e            req_type_i,
  input logic                     rsp_valid_i,
  input logic                     rsp_ready_i,
  input logic [eia_pkg::ID_W-1:0] rsp_granted_id_i,
  input eia_pkg::status_e         rsp_status_i
);

  logic          push;
  logic          pop;
  logic [1:0]    cnt_q, cnt_d;
  logic [1:0]    wr_slot;
  eia_pkg::req_e q_q [2];
  eia_pkg::req_e q_d [2];

  assign push    = req_valid_i && req_ready_i;
  assign pop     = rsp_valid_i && rsp_ready_i;
  assign wr_slot = cnt_q - {1'b0, pop};
  assign cnt_d   = cnt_q + {1'b0, push} - {1'b0, pop};

  // Track request types in flight, oldest at slot zero.
  always_comb begin
    q_d[0] = q_q[0];
    q_d[1] = q_q[1];
    if (pop) begin
      q_d[0] = q_q[1];
    end
    if (push) begin
      if (wr_slot == 2'd0) begin
        q_d[0] = req_type_i;
      end else begin
        q_d[1] = req_type_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      q_q[0] <= eia_pkg::REQ_ALLOC;
      q_q[1] <= eia_pkg::REQ_ALLOC;
    end else begin
      cnt_q  <= cnt_d;
      q_q[0] <= q_d[0];
      q_q[1] <= q_d[1];
    end
  end

  a_inflight_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("more than two requests in flight");

  a_no_orphan_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> cnt_q != 2'd0)
    else $error("response without an outstanding request");

  a_zero_id : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && q_q[0] != eia_pkg::REQ_ALLOC) |-> rsp_granted_id_i == '0)
    else $error("nonzero ID on a response to a non-allocate request");

  a_exhaust_alloc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && rsp_status_i == eia_pkg::ST_EXHAUSTED) |-> q_q[0] == eia_pkg::REQ_ALLOC)
    else $error("exhausted status on a non-allocate request");

  a_rsp_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_granted_id_i) && $stable(rsp_status_i)))
    else $error("stalled response beat changed");

endmodule

bind entity_id_allocator eia_checker u_eia_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .req_type_i       (req_i.req_type),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_granted_id_i (rsp_o.granted_id),
  .rsp_status_i     (rsp_o.status)
);
